// ===== src/lrk4_pkg.sv =====
`timescale 1ns / 1ps

package lrk4_pkg;

    localparam int NUM_STAGES = 31;

    localparam logic [20:0] TIME_STEP_RST = 21'd10486;
    localparam logic [30:0] SIGMA_RST     = 31'd10485760;
    localparam logic [30:0] RHO_RST       = 31'd29360128;
    localparam logic [30:0] BETA_RST      = 31'd2796203;

    // clamp limits for floor(t / 3) to stay inside 32 bits
    localparam logic signed [63:0] DIV_HI  = 64'sd6442450943;
    localparam logic signed [63:0] DIV_LO  = -64'sd6442450944;
    localparam logic signed [63:0] DIV_OFS = 64'sd6442450944;
    localparam logic [33:0]        DIV_MAX = 34'h2FFFFFFFF;

    // (2^35 + 1) / 3, exact floor(u / 3) as (u * RCP3) >> 35 for u < 2^35
    localparam logic [33:0] RCP3    = 34'd11453246123;
    localparam logic [16:0] RCP3_LO = RCP3[16:0];
    localparam logic [16:0] RCP3_HI = RCP3[33:17];

    typedef logic [31:0] word_t;

    typedef enum logic [1:0] {
        REG_TIME_STEP,
        REG_SIGMA,
        REG_RHO,
        REG_BETA
    } reg_idx_t;

    typedef enum logic [3:0] {
        OP_DIFF,
        OP_MUL,
        OP_RND,
        OP_COMB,
        OP_SMUL,
        OP_SRND,
        OP_SADD,
        OP_SUM,
        OP_FMUL,
        OP_FSCALE,
        OP_RCP,
        OP_QUO,
        OP_FOUT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] arg;
    } stage_t;

    typedef struct packed {
        logic [2:0][31:0]      p;
        logic [2:0][31:0]      q;
        logic [3:0][2:0][31:0] kk;
        logic [1:0][31:0]      d;
        logic [3:0][63:0]      m;
        logic [3:0][31:0]      r;
        logic [2:0][34:0]      s;
        logic [2:0][35:0]      u;
        logic [2:0][50:0]      pl;
        logic [2:0][50:0]      ph;
        logic [2:0][35:0]      quo;
        logic                  last;
    } item_t;

    // slope: diff, mul, round, combine; advance: mul, round (arg 1 = half), add
    localparam stage_t PLAN [NUM_STAGES] = '{
        '{OP_DIFF, 2'd0}, '{OP_MUL, 2'd0}, '{OP_RND, 2'd0}, '{OP_COMB, 2'd0},
        '{OP_SMUL, 2'd0}, '{OP_SRND, 2'd1}, '{OP_SADD, 2'd0},
        '{OP_DIFF, 2'd0}, '{OP_MUL, 2'd0}, '{OP_RND, 2'd0}, '{OP_COMB, 2'd1},
        '{OP_SMUL, 2'd1}, '{OP_SRND, 2'd1}, '{OP_SADD, 2'd0},
        '{OP_DIFF, 2'd0}, '{OP_MUL, 2'd0}, '{OP_RND, 2'd0}, '{OP_COMB, 2'd2},
        '{OP_SMUL, 2'd2}, '{OP_SRND, 2'd0}, '{OP_SADD, 2'd0},
        '{OP_DIFF, 2'd0}, '{OP_MUL, 2'd0}, '{OP_RND, 2'd0}, '{OP_COMB, 2'd3},
        '{OP_SUM, 2'd0}, '{OP_FMUL, 2'd0}, '{OP_FSCALE, 2'd0},
        '{OP_RCP, 2'd0}, '{OP_QUO, 2'd0},
        '{OP_FOUT, 2'd0}
    };

    function automatic logic signed [63:0] sext(input word_t v);
        return $signed({{32{v[31]}}, v});
    endfunction

    function automatic word_t sat32(input logic signed [63:0] v);
        if (v > 64'sh7FFFFFFF)
            return 32'h7FFFFFFF;
        else if (v < -64'sh80000000)
            return 32'h80000000;
        else
            return v[31:0];
    endfunction

    // round to nearest, ties up, then saturate
    function automatic word_t rnd_sat(input logic [63:0] m, input logic half);
        logic signed [63:0] t;
        if (half)
            t = ($signed(m) + 64'sd1048576) >>> 21;
        else
            t = ($signed(m) + 64'sd524288) >>> 20;
        return sat32(t);
    endfunction

endpackage

// ===== src/lorenz_rk4_step.sv =====
`timescale 1ns / 1ps

// lorenz_rk4_step: one classical rk4 step of the lorenz system per point
//
// input channel: in_valid / in_ready carry pos_x, pos_y, pos_z (signed
// q11.20) and last_point; output channel: out_valid / out_ready carry
// next_x, next_y, next_z and batch_end, the copy of last_point
// configuration: cfg_we writes cfg_data into register cfg_index
// (0 time_step, 1 sigma_coef, 2 rho_coef, 3 beta_coef); write only while
// the pipeline is empty
//
// pipeline: 31 register stages, one beat per cycle while the output is not
// stalled (four slope evaluations of four stages, three advances of three
// stages, a six-stage final combine including a reciprocal multiply for
// the divide by three)
// reset: empties the pipeline and restores the coefficient defaults
// stall: a stage holds while the stage after it is full and held; bubbles
// are squeezed out, so input keeps flowing until every stage is full
module lorenz_rk4_step (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] pos_z,
    input  logic        last_point,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] next_x,
    output logic [31:0] next_y,
    output logic [31:0] next_z,
    output logic        batch_end
);
    import lrk4_pkg::*;

    logic [20:0] time_step_reg;
    logic [30:0] sigma_coef_reg;
    logic [30:0] rho_coef_reg;
    logic [30:0] beta_coef_reg;

    item_t                 in_item;
    item_t                 pipe_reg  [NUM_STAGES];
    item_t                 pipe_next [NUM_STAGES];
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES:0]   adv;

    // coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg  <= TIME_STEP_RST;
            sigma_coef_reg <= SIGMA_RST;
            rho_coef_reg   <= RHO_RST;
            beta_coef_reg  <= BETA_RST;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_TIME_STEP: time_step_reg  <= cfg_data[20:0];
                REG_SIGMA:     sigma_coef_reg <= cfg_data;
                REG_RHO:       rho_coef_reg   <= cfg_data;
                REG_BETA:      beta_coef_reg  <= cfg_data;
                default:       ;
            endcase
        end
    end

    // one pipeline stage worth of work, picked by the stage plan
    function automatic item_t run_stage(input op_t op, input logic [1:0] arg,
                                        input item_t a);
        item_t              o;
        logic signed [63:0] w;
        logic [35:0]        u;
        logic [68:0]        pr;
        o = a;
        case (op)
            OP_DIFF:
            begin
                o.d[0] = sat32(sext(a.q[1]) - sext(a.q[0]));
                o.d[1] = sat32($signed({33'd0, rho_coef_reg}) - sext(a.q[2]));
            end
            OP_MUL:
            begin
                o.m[0] = $signed({1'b0, sigma_coef_reg}) * $signed(a.d[0]);
                o.m[1] = $signed(a.q[0]) * $signed(a.d[1]);
                o.m[2] = $signed(a.q[0]) * $signed(a.q[1]);
                o.m[3] = $signed({1'b0, beta_coef_reg}) * $signed(a.q[2]);
            end
            OP_RND:
            begin
                for (int i = 0; i < 4; i++)
                    o.r[i] = rnd_sat(a.m[i], 1'b0);
            end
            OP_COMB:
            begin
                o.kk[arg][0] = a.r[0];
                o.kk[arg][1] = sat32(sext(a.r[1]) - sext(a.q[1]));
                o.kk[arg][2] = sat32(sext(a.r[2]) - sext(a.r[3]));
            end
            OP_SMUL:
            begin
                for (int i = 0; i < 3; i++)
                    o.m[i] = $signed(a.kk[arg][i]) * $signed({1'b0, time_step_reg});
            end
            OP_SRND:
            begin
                for (int i = 0; i < 3; i++)
                    o.r[i] = rnd_sat(a.m[i], arg[0]);
            end
            OP_SADD:
            begin
                for (int i = 0; i < 3; i++)
                    o.q[i] = sat32(sext(a.p[i]) + sext(a.r[i]));
            end
            OP_SUM:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    w = sext(a.kk[0][i]) + (sext(a.kk[1][i]) <<< 1)
                        + (sext(a.kk[2][i]) <<< 1) + sext(a.kk[3][i]);
                    o.s[i] = w[34:0];
                end
            end
            OP_FMUL:
            begin
                for (int i = 0; i < 3; i++)
                    o.m[i] = $signed(a.s[i]) * $signed({1'b0, time_step_reg});
            end
            OP_FSCALE:
            begin
                // divide by 6 * 2^20 as a shift by 21 then a divide by 3,
                // offset so the divide works on a non-negative value
                for (int i = 0; i < 3; i++)
                begin
                    w = ($signed(a.m[i]) + 64'sd3145728) >>> 21;
                    if (w > DIV_HI)
                        u = {2'b00, DIV_MAX};
                    else if (w < DIV_LO)
                        u = '0;
                    else
                    begin
                        w = w + DIV_OFS;
                        u = {2'b00, w[33:0]};
                    end
                    o.u[i]   = u;
                    o.quo[i] = '0;
                end
            end
            OP_RCP:
            begin
                // reciprocal of three in two 17-bit halves
                for (int i = 0; i < 3; i++)
                begin
                    o.pl[i] = a.u[i][33:0] * RCP3_LO;
                    o.ph[i] = a.u[i][33:0] * RCP3_HI;
                end
            end
            OP_QUO:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    pr       = {1'b0, a.ph[i], 17'd0} + {18'd0, a.pl[i]};
                    o.quo[i] = {2'b00, pr[68:35]};
                end
            end
            OP_FOUT:
            begin
                // undo the offset: quotient minus 2^31 is an msb flip
                for (int i = 0; i < 3; i++)
                    o.q[i] = sat32(sext(a.p[i])
                                   + sext({~a.quo[i][31], a.quo[i][30:0]}));
            end
            default: ;
        endcase
        return o;
    endfunction

    always_comb
    begin
        in_item      = '0;
        in_item.p[0] = pos_x;
        in_item.p[1] = pos_y;
        in_item.p[2] = pos_z;
        in_item.q    = in_item.p;
        in_item.last = last_point;
    end

    // a stage may load when it is empty or its beat moves on
    assign adv[NUM_STAGES] = out_ready;
    assign in_ready        = adv[0];

    for (genvar g = 0; g < NUM_STAGES; g++)
    begin : g_stage
        assign adv[g] = ~valid_reg[g] | adv[g+1];

        if (g == 0)
        begin : g_first
            always_comb
                pipe_next[g] = run_stage(PLAN[g].op, PLAN[g].arg, in_item);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[g] <= 1'b0;
                else if (adv[g])
                    valid_reg[g] <= in_valid;
            end
        end
        else
        begin : g_rest
            always_comb
                pipe_next[g] = run_stage(PLAN[g].op, PLAN[g].arg, pipe_reg[g-1]);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[g] <= 1'b0;
                else if (adv[g])
                    valid_reg[g] <= valid_reg[g-1];
            end
        end

        // payload, no reset
        always_ff @(posedge clk)
        begin
            if (adv[g])
                pipe_reg[g] <= pipe_next[g];
        end
    end

    assign out_valid = valid_reg[NUM_STAGES-1];
    assign next_x    = pipe_reg[NUM_STAGES-1].q[0];
    assign next_y    = pipe_reg[NUM_STAGES-1].q[1];
    assign next_z    = pipe_reg[NUM_STAGES-1].q[2];
    assign batch_end = pipe_reg[NUM_STAGES-1].last;

    // an empty output slot lets every stage advance
    a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[NUM_STAGES-1] |-> in_ready)
        else $error("input blocked while output stage empty");

    // a full pipeline held at the output takes no new beat
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (&valid_reg && !out_ready) |-> !in_ready)
        else $error("input accepted into a full stalled pipeline");

    // a held first stage keeps its beat
    a_first_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[0] && !adv[1]) |=> (valid_reg[0] && $stable(pipe_reg[0])))
        else $error("first stage lost a stalled beat");

endmodule
